[hdl/tile_store_with_box_collision_defines.svh]
// assertion macros shared by the checker files
`ifndef TILE_STORE_WITH_BOX_COLLISION_DEFINES_SVH
`define TILE_STORE_WITH_BOX_COLLISION_DEFINES_SVH

// same-cycle implication, checked at every clock outside reset
`define TSBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every clock outside reset
`define TSBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tsbc_pkg.sv]
`default_nettype none

package tsbc_pkg;

  // table geometry
  localparam int MaxTiles = 256;
  localparam int IdxW     = (MaxTiles > 1) ? $clog2(MaxTiles) : 1;
  localparam int CntW     = $clog2(MaxTiles + 1);

  // tile geometry in pixels times 16
  localparam int TileSize = 10;
  localparam int FracBits = 4;
  localparam int TilePix  = TileSize << FracBits;

  // internal position and doubled difference widths
  localparam int PosW    = 24;
  localparam int DiffW   = PosW + 2;
  localparam int OutPosW = 20;

  // configuration port
  localparam int CfgW    = 8;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_PLAYER_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PLAYER_HEIGHT = 1'b1;
  localparam logic [CfgW-1:0]    PlayerSizeReset   = 8'd30;

  // operation codes; the unused code behaves as collide
  localparam logic [1:0] MODE_PLACE   = 2'd0;
  localparam logic [1:0] MODE_ERASE   = 2'd1;
  localparam logic [1:0] MODE_COLLIDE = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_PLACED   = 3'd0;
  localparam logic [2:0] STAT_OCCUPIED = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_REMOVED  = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;
  localparam logic [2:0] STAT_COLLIDE  = 3'd5;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [11:0] cell_x;
    logic signed [11:0] cell_y;
    logic [1:0]         tile_kind;
    logic signed [19:0] player_x;
    logic signed [19:0] player_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [8:0]         tile_count;
    logic signed [19:0] new_player_x;
    logic signed [19:0] new_player_y;
    logic               top_contact;
    logic               stop_vertical;
  } out_item_t;

  typedef struct packed {
    logic signed [11:0] col;
    logic signed [11:0] row;
    logic [1:0]         kind;
  } tile_entry_t;

  localparam int EntryW = $bits(tile_entry_t);

  // controller to datapath
  typedef struct packed {
    logic       start;
    logic       rd_next;
    logic       place_wr;
    logic       shift_wr;
    logic       dec_count;
    logic       col_stage1;
    logic       col_stage2;
    logic       load_out;
    logic [2:0] status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       scan_end;
    logic       match;
    logic       pending;
    logic       out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

[hdl/tsbc_ram.sv]
`default_nettype none

module tsbc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] wr_addr,
  input  logic [Width-1:0]              wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] rd_addr,
  output logic [Width-1:0]              rd_data
);

  logic [Width-1:0] mem_r [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/tsbc_ctrl.sv]
`default_nettype none

module tsbc_ctrl
  import tsbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_COL_RD,
    S_COL_S1,
    S_COL_S2,
    S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] status_r, status_nxt;

  // new transactions only enter while idle
  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.mode == MODE_PLACE) begin
          if (stat.full) begin
            status_nxt = STAT_FULL;
            state_nxt  = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (stat.mode == MODE_ERASE) begin
          state_nxt = S_SCAN;
        end else begin
          status_nxt = STAT_COLLIDE;
          state_nxt  = S_COL_RD;
        end
      end
      S_SCAN: begin
        // read ahead one entry, compare the one that just came back
        cmd.rd_next = !stat.scan_end;
        if (stat.match) begin
          if (stat.mode == MODE_PLACE) begin
            status_nxt = STAT_OCCUPIED;
            state_nxt  = S_FINISH;
          end else begin
            status_nxt = STAT_REMOVED;
            state_nxt  = S_SHIFT;
          end
        end else if (stat.scan_end) begin
          if (stat.mode == MODE_PLACE) begin
            cmd.place_wr = 1'b1;
            status_nxt   = STAT_PLACED;
          end else begin
            status_nxt = STAT_NOTFOUND;
          end
          state_nxt = S_FINISH;
        end
      end
      S_SHIFT: begin
        // move each later entry down by one
        cmd.rd_next  = !stat.scan_end;
        cmd.shift_wr = stat.pending;
        if (stat.scan_end && !stat.pending) begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_COL_RD: begin
        if (stat.scan_end) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_COL_S1;
        end
      end
      S_COL_S1: begin
        cmd.col_stage1 = 1'b1;
        state_nxt      = S_COL_S2;
      end
      S_COL_S2: begin
        cmd.col_stage2 = 1'b1;
        if (stat.scan_end) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_COL_S1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= STAT_PLACED;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/tsbc_dp.sv]
`default_nettype none

module tsbc_dp
  import tsbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  in_item_t           in_data,
  input  logic               cfg_valid,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output logic               cfg_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  ctrl_cmd_t          cmd,
  output ctrl_stat_t         stat
);

  localparam logic signed [PosW-1:0]  TPix  = PosW'(TilePix);
  localparam logic signed [DiffW-1:0] TPixD = DiffW'(TilePix);
  localparam logic signed [PosW-1:0]  PosHi = PosW'((2 ** (OutPosW - 1)) - 1);
  localparam logic signed [PosW-1:0]  PosLo = PosW'(-(2 ** (OutPosW - 1)));

  in_item_t               item_r;
  logic [CntW-1:0]        count_r;
  logic [CntW-1:0]        idx_r;
  logic [CntW-1:0]        shift_addr;
  logic                   chk_v_r;
  logic signed [PosW-1:0] px_r, py_r, px_nxt, py_nxt;
  logic                   top_r, top_nxt, stopv_r, stopv_nxt;
  logic                   ov_r, ov_nxt;
  logic signed [DiffW-1:0] sx2_r, sy2_r, sx2_nxt, sy2_nxt;
  logic [CfgW-1:0]        width_r, height_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic [EntryW-1:0]      rd_word;
  tile_entry_t            rd_ent, wr_ent;
  logic                   wr_en;
  logic [IdxW-1:0]        wr_addr;

  logic signed [PosW-1:0]  pw, ph, tx, ty;
  logic signed [DiffW-1:0] pw_d, ph_d, ax, ay, dx2, dy2, hx, hy;

  function automatic logic [OutPosW-1:0] sat_pos(input logic signed [PosW-1:0] v);
    logic signed [PosW-1:0] c;
    c = v;
    if (v > PosHi) begin
      c = PosHi;
    end else if (v < PosLo) begin
      c = PosLo;
    end
    return c[OutPosW-1:0];
  endfunction

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= PlayerSizeReset;
      height_r <= PlayerSizeReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PLAYER_WIDTH:  width_r  <= cfg_data;
        CFG_PLAYER_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // tile table
  assign rd_ent     = tile_entry_t'(rd_word);
  assign shift_addr = idx_r - CntW'(2);
  assign wr_en      = cmd.place_wr | cmd.shift_wr;
  assign wr_addr    = cmd.place_wr ? count_r[IdxW-1:0] : shift_addr[IdxW-1:0];

  always_comb begin
    if (cmd.place_wr) begin
      wr_ent.col  = item_r.cell_x;
      wr_ent.row  = item_r.cell_y;
      wr_ent.kind = item_r.tile_kind;
    end else begin
      wr_ent = rd_ent;
    end
  end

  tsbc_ram #(
    .Width (EntryW),
    .Depth (MaxTiles)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (cmd.rd_next),
    .rd_addr (idx_r[IdxW-1:0]),
    .rd_data (rd_word)
  );

  // walk pointer and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      chk_v_r <= 1'b0;
    end else begin
      chk_v_r <= cmd.rd_next;
      if (cmd.start) begin
        idx_r <= '0;
      end else if (cmd.rd_next) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.place_wr) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.dec_count) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // box sizes in pixels times 16
  assign pw   = PosW'(width_r) << FracBits;
  assign ph   = PosW'(height_r) << FracBits;
  assign pw_d = DiffW'(pw);
  assign ph_d = DiffW'(ph);

  // stage one: tile corner, strict overlap, doubled center differences
  always_comb begin
    tx      = PosW'(rd_ent.col) * TPix;
    ty      = PosW'(rd_ent.row) * TPix;
    ov_nxt  = (tx < px_r + pw) && (tx + TPix > px_r) &&
              (ty < py_r + ph) && (ty + TPix > py_r);
    sx2_nxt = (DiffW'(tx) <<< 1) + TPixD - (DiffW'(px_r) <<< 1) - pw_d;
    sy2_nxt = (DiffW'(ty) <<< 1) + TPixD - (DiffW'(py_r) <<< 1) - ph_d;
  end

  // stage two: push out along the axis of least penetration
  always_comb begin
    ax        = (sx2_r < 0) ? -sx2_r : sx2_r;
    ay        = (sy2_r < 0) ? -sy2_r : sy2_r;
    dx2       = TPixD + pw_d - ax;
    dy2       = TPixD + ph_d - ay;
    hx        = dx2 >>> 1;
    hy        = dy2 >>> 1;
    px_nxt    = px_r;
    py_nxt    = py_r;
    top_nxt   = top_r;
    stopv_nxt = stopv_r;
    if (ov_r) begin
      if (dx2 < dy2) begin
        if (sx2_r < 0) begin
          px_nxt = px_r + PosW'(hx);
        end else begin
          px_nxt = px_r - PosW'(hx);
        end
      end else begin
        if (sy2_r > 0) begin
          top_nxt = 1'b1;
        end
        if (sy2_r < 0) begin
          py_nxt = py_r + PosW'(hy);
        end else begin
          py_nxt = py_r - PosW'(hy);
        end
        stopv_nxt = 1'b1;
      end
    end
  end

  // transaction registers and collision state
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_r  <= in_data;
      px_r    <= PosW'(in_data.player_x);
      py_r    <= PosW'(in_data.player_y);
      top_r   <= 1'b0;
      stopv_r <= 1'b0;
    end else if (cmd.col_stage2) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      top_r   <= top_nxt;
      stopv_r <= stopv_nxt;
    end
    if (cmd.col_stage1) begin
      ov_r  <= ov_nxt;
      sx2_r <= sx2_nxt;
      sy2_r <= sy2_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.status        <= cmd.status;
      out_r.tile_count    <= 9'(count_r);
      out_r.new_player_x  <= sat_pos(px_r);
      out_r.new_player_y  <= sat_pos(py_r);
      out_r.top_contact   <= top_r;
      out_r.stop_vertical <= stopv_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status back to the controller
  assign stat.mode     = item_r.mode;
  assign stat.full     = (count_r == CntW'(MaxTiles));
  assign stat.scan_end = (idx_r == count_r);
  assign stat.match    = chk_v_r && (rd_ent.col == item_r.cell_x) &&
                         (rd_ent.row == item_r.cell_y);
  assign stat.pending  = chk_v_r;
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

[hdl/tile_store_with_box_collision.sv]
// Tile table of up to 256 grid cells with player box push-out. Each input
// transaction places a tile, erases the first tile at a cell (later entries
// move down one slot) or walks all stored tiles and pushes the player box out
// of each 10x10 pixel tile it strictly overlaps, along the axis of least
// penetration. One result per transaction. A full table rejects a place
// without a scan. The entries sit in one RAM with a single registered read
// port, so place and erase step through one entry per cycle, and collide works
// on one tile at a time because each push feeds the overlap test of the next
// tile. One transaction is worked on at a time; a new one is taken while the
// previous result is still waiting in the output register. The user must
// write the player size registers through the cfg port only while no
// transaction is active; the block itself does not enforce this.
`default_nettype none

module tile_store_with_box_collision
  import tsbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencer
  tsbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table, collision arithmetic and result register
  tsbc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

[hdl/tsbc_chk.sv]
`default_nettype none
`include "tile_store_with_box_collision_defines.svh"

module tsbc_chk
  import tsbc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  `TSBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // a full table reports the full count
  `TSBC_ASSERT_NOW(a_full_count, out_valid && out_data.status == STAT_FULL, out_data.tile_count == 9'(MaxTiles), "full status without full count")

  // only collide results carry contact flags
  `TSBC_ASSERT_NOW(a_flags_collide, out_valid && out_data.status != STAT_COLLIDE, !out_data.top_contact && !out_data.stop_vertical, "contact flags on table result")

  // landing on a tile is a vertical push
  `TSBC_ASSERT_NOW(a_top_stop, out_valid && out_data.top_contact, out_data.stop_vertical, "top contact without vertical stop")

endmodule

bind tile_store_with_box_collision tsbc_chk u_chk (.*);

`default_nettype wire
